// ===== hdl/rank_roulette_select_core_macros.svh =====
// ----------------------------------------------------------------------------
// rank_roulette_select_core_macros.svh
// assertion macros shared by the rank roulette selection core
// ----------------------------------------------------------------------------
`ifndef RANK_ROULETTE_SELECT_CORE_MACROS_SVH
`define RANK_ROULETTE_SELECT_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define RRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// types, widths and the rank weight sum table of the rank roulette selector
// ----------------------------------------------------------------------------
package rrs_pkg;

    // population limits
    localparam int POP_MAX     = 64;
    localparam int MIN_POP     = 2;
    localparam int COUNT_RESET = 64;

    // fixed field widths
    localparam int CNT_W = 7;
    localparam int RV_W  = 31;
    localparam int SEL_W = 6;

    // derived widths
    localparam int IDX_W   = $clog2(POP_MAX);
    localparam int N_W     = $clog2(POP_MAX + 1);
    localparam int SQ_W    = 2 * IDX_W;
    localparam int SUM_MAX = (POP_MAX - 1) * POP_MAX * (2 * POP_MAX - 1) / 6;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int CMP_W   = (SQ_W > SUM_W) ? SQ_W : SUM_W;
    localparam int STEP_W  = $clog2(RV_W);

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MOD  = 3'b010,
        ST_SCAN = 3'b100
    } t_state;

    // token handed from cell to cell along the scan chain
    typedef struct packed {
        logic             valid;
        logic             live;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] gap;
        logic [SQ_W-1:0]  sq;
        logic [SUM_W-1:0] resid;
    } t_token;

    // entry n holds the sum of k^2 for k below n
    typedef logic [SUM_W-1:0] t_sum_tab [0:POP_MAX];

    function automatic t_sum_tab build_sum_tab();
        t_sum_tab         tab;
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int k = 0; k <= POP_MAX; k++) begin
            tab[k] = acc;
            acc    = acc + SUM_W'(k * k);
        end
        return tab;
    endfunction

    localparam t_sum_tab SUM_TABLE = build_sum_tab();

endpackage

// ===== hdl/rrs_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_mod_unit
// bit-serial restoring modulo, one dividend bit per cycle
// ----------------------------------------------------------------------------
module rrs_mod_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rrs_pkg::RV_W-1:0]  i_dividend,
    input  logic [rrs_pkg::SUM_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rrs_pkg::SUM_W-1:0] o_rem
);
    import rrs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [RV_W-1:0]   r_dvd;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  n_rem;
    logic [SUM_W:0]    w_shift;

    // shift in the next dividend bit and take off the divisor if it fits
    always_comb begin
        w_shift = {r_rem, r_dvd[RV_W-1]};
        if (w_shift >= {1'b0, i_divisor}) begin
            n_rem = SUM_W'(w_shift - {1'b0, i_divisor});
        end else begin
            n_rem = SUM_W'(w_shift);
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= STEP_W'(RV_W - 1);
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - STEP_W'(1);
            r_dvd <= {r_dvd[RV_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/rrs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_cell
// one rank of the scan chain: tests the running residue against one weight
// ----------------------------------------------------------------------------
module rrs_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  rrs_pkg::t_token i_tok,
    output rrs_pkg::t_token o_tok
);
    import rrs_pkg::*;

    t_token r_tok;
    t_token n_tok;

    // weight test, then step the square down to the next rank
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && i_tok.live && !i_tok.found) begin
            if (CMP_W'(i_tok.sq) > CMP_W'(i_tok.resid)) begin
                n_tok.found = 1'b1;
            end else begin
                n_tok.resid = i_tok.resid - SUM_W'(i_tok.sq);
                n_tok.idx   = i_tok.idx + IDX_W'(1);
                n_tok.gap   = i_tok.gap - IDX_W'(1);
                n_tok.sq    = i_tok.sq - SQ_W'({i_tok.gap, 1'b0}) + SQ_W'(1);
                n_tok.live  = (i_tok.gap != '0);
            end
        end
    end

    // token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hdl/rank_roulette_select_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_roulette_select_core
// rank based roulette selection: random value modulo total weight, then a
// scan for the first rank whose running weight sum passes it
// ----------------------------------------------------------------------------
//  channel    dir  contents
//  s_axis     in   tdata[30:0] random_value
//  m_axis     out  tdata[5:0]  selected_index
//  i_cfg_wr   in   population_count, 7 bits
//
//  an item passes through the serial modulo, then the token walks the 64-cell
//  scan chain, one cell per cycle while the output is not stalled.
//  a new item is taken once the previous result sits in the output register.
//  a stalled output freezes the chain with the token in the last cell.
//  synchronous active-low reset; population_count resets to 64.
// ----------------------------------------------------------------------------
`include "rank_roulette_select_core_macros.svh"

module rank_roulette_select_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [rrs_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,  // [30:0] random_value
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata   // [5:0] selected_index
);
    import rrs_pkg::*;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_total;
    logic [IDX_W-1:0] r_dist0;
    logic [SQ_W-1:0]  r_sq0;
    logic             r_out_valid;
    logic [SEL_W-1:0] r_sel;

    logic [N_W-1:0]   w_n;
    logic [IDX_W-1:0] w_d;
    logic             w_in_xfer;
    logic             w_mod_done;
    logic [SUM_W-1:0] w_mod_rem;
    logic             w_cap;
    logic             w_en;
    t_token           w_tok [0:POP_MAX];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(COUNT_RESET);
        end else if (i_cfg_wr_en) begin
            r_count <= i_cfg_wr_data;
        end
    end

    // clamp the population into the usable range
    always_comb begin
        if (int'(r_count) < MIN_POP) begin
            w_n = N_W'(MIN_POP);
        end else if (int'(r_count) > POP_MAX) begin
            w_n = N_W'(POP_MAX);
        end else begin
            w_n = N_W'(r_count);
        end
        w_d = IDX_W'(w_n - N_W'(1));
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // per-item constants, taken at the input transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_total <= SUM_TABLE[w_n];
            r_dist0 <= w_d;
            r_sq0   <= SQ_W'(w_d) * SQ_W'(w_d);
        end
    end

    // serial modulo
    rrs_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_xfer),
        .i_dividend (s_axis_tdata[RV_W-1:0]),
        .i_divisor  (r_total),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // token entering the chain
    always_comb begin
        w_tok[0].valid = w_mod_done;
        w_tok[0].live  = 1'b1;
        w_tok[0].found = 1'b0;
        w_tok[0].idx   = '0;
        w_tok[0].gap   = r_dist0;
        w_tok[0].sq    = r_sq0;
        w_tok[0].resid = w_mod_rem;
    end

    // chain advances unless a finished token cannot leave
    assign w_cap = w_tok[POP_MAX].valid && (!r_out_valid || m_axis_tready);
    assign w_en  = !w_tok[POP_MAX].valid || w_cap;

    // scan chain, one cell per rank
    for (genvar g = 0; g < POP_MAX; g++) begin : g_cell
        rrs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) r_state <= ST_MOD;
                end
                ST_MOD: begin
                    if (w_mod_done) r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (w_cap) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cap) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_sel <= w_tok[POP_MAX].found ? SEL_W'(w_tok[POP_MAX].idx) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - SEL_W){1'b0}}, r_sel};

    // checks
    `RRS_ASSERT_NOW(a_rem_below_total, w_mod_done, w_mod_rem < r_total, "remainder not below total")
    `RRS_ASSERT_NOW(a_done_in_mod, w_mod_done, r_state == ST_MOD, "modulo finished outside its phase")
    `RRS_ASSERT_NOW(a_token_found, w_tok[POP_MAX].valid, w_tok[POP_MAX].found, "scan ended without a hit")
    `RRS_ASSERT_NOW(a_index_in_range, w_tok[POP_MAX].valid, w_tok[POP_MAX].idx < r_dist0, "selected rank out of range")

endmodule

// ===== sim/rank_roulette_select_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_roulette_select_core_tb
// self-checking bench for the rank roulette selector: random values are
// streamed in under several population settings and idle patterns, each
// returned rank is compared with an in-bench prediction of the selection
// ----------------------------------------------------------------------------
module rank_roulette_select_core_tb;
    import rrs_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int RESET_TICKS = 7;
    localparam int LONG_HOLD   = 400;
    localparam int DOG_LIMIT   = 5000;
    localparam int TAIL_TICKS  = 200;
    localparam int PHASE_ITEMS = 47;
    localparam logic [RV_W-1:0] RV_ALL = {RV_W{1'b1}};

    // one expected selection and the value that caused it
    typedef struct {
        logic [RV_W-1:0]  value;
        logic [SEL_W-1:0] rank;
    } t_pick;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // [30:0] random_value
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;        // [5:0] selected_index

    logic [RV_W-1:0]   pending_values[$];
    t_pick             expected_picks[$];
    logic [CNT_W-1:0]  population_shadow = CNT_W'(COUNT_RESET);
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_req_seq = 0;
    int                hold_seen_seq = 0;
    int                hold_left = 0;
    int                error_count = 0;
    int                dog_count = 0;

    rank_roulette_select_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // population actually used: clamped to the legal range
    function automatic int unsigned clamp_population(logic [CNT_W-1:0] pop);
        int unsigned n;
        n = pop;
        if (n < MIN_POP) n = MIN_POP;
        if (n > POP_MAX) n = POP_MAX;
        return n;
    endfunction

    // sum of squares 0 .. n-1
    function automatic int unsigned weight_total(int unsigned n);
        int unsigned acc;
        acc = 0;
        for (int unsigned k = 0; k < n; k++) acc += k * k;
        return acc;
    endfunction

    // rank chosen for a random value under a given population setting
    function automatic logic [SEL_W-1:0] predict_rank(logic [CNT_W-1:0] pop,
                                                      logic [RV_W-1:0] value);
        int unsigned n;
        int unsigned arrow;
        int unsigned running;
        logic        hit;
        logic [SEL_W-1:0] rank;
        n       = clamp_population(pop);
        arrow   = value % weight_total(n);
        running = 0;
        hit     = 1'b0;
        rank    = '0;
        for (int unsigned i = 0; i < n; i++) begin
            running += (n - 1 - i) * (n - 1 - i);
            if (!hit && running > arrow) begin
                hit  = 1'b1;
                rank = SEL_W'(i);
            end
        end
        return rank;
    endfunction

    // random value: full range, up to three times the total, wrapped multiples, rank edges
    function automatic logic [RV_W-1:0] draw_value(logic [CNT_W-1:0] pop);
        int unsigned n;
        int unsigned total;
        int unsigned edge_sum;
        int unsigned k;
        logic [RV_W-1:0] rv;
        n     = clamp_population(pop);
        total = weight_total(n);
        rv    = '0;
        case ($urandom_range(3))
            0: rv = RV_W'($urandom);
            1: rv = RV_W'($urandom_range(3 * total));
            2: rv = RV_W'((($urandom & RV_ALL) / total) * total + $urandom_range(total - 1));
            default: begin
                k        = $urandom_range(n - 1);
                edge_sum = 0;
                for (int unsigned i = 0; i <= k; i++) edge_sum += (n - 1 - i) * (n - 1 - i);
                rv = RV_W'(edge_sum - $urandom_range(1));
            end
        endcase
        return rv;
    endfunction

    // sender: offers queued values, records the prediction on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                t_pick pick;
                pick.value     = s_axis_tdata[RV_W-1:0];
                pick.rank      = predict_rank(population_shadow, s_axis_tdata[RV_W-1:0]);
                expected_picks = {expected_picks, pick};
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, pending_values.pop_front()};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus the occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_picks.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none actual rank %0d",
                             $time, m_axis_tdata[SEL_W-1:0]);
                end else begin
                    t_pick want;
                    want = expected_picks.pop_front();
                    if (m_axis_tdata[SEL_W-1:0] !== want.rank) begin
                        error_count++;
                        $display("%0t: rank mismatch for value %0d, expected %0d actual %0d",
                                 $time, want.value, want.rank, m_axis_tdata[SEL_W-1:0]);
                    end
                end
            end
            if (hold_req_seq != hold_seen_seq) begin
                hold_seen_seq = hold_req_seq;
                hold_left     = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            dog_count = 0;
        else
            dog_count++;
        if (dog_count >= DOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, DOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // wait until every queued value has gone and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_values.size() != 0 || s_axis_tvalid || expected_picks.size() != 0);
    endtask

    // population write, only once the block is idle
    task automatic write_population(logic [CNT_W-1:0] pop);
        wait_drained();
        repeat (3) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_wr_en      <= 1'b1;
        i_cfg_wr_data    <= pop;
        population_shadow = pop;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    // stimulus sequence
    initial begin
        logic [CNT_W-1:0] phase_pops[9];
        phase_pops = '{CNT_W'(2), CNT_W'(127), CNT_W'(3), CNT_W'(0), CNT_W'(33),
                       CNT_W'(1), CNT_W'(65), CNT_W'(64), CNT_W'(50)};

        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset population of 64, rank edges and field extremes
        set_idling(0);
        pending_values = '{RV_W'(0), RV_W'(1), RV_W'(3968), RV_W'(3969), RV_W'(7812),
                           RV_W'(7813), RV_W'(85343), RV_W'(85344), RV_W'(85345),
                           RV_ALL, RV_W'(31'h2AAAAAAA), RV_W'(31'h55555555)};
        // population below two behaves as two
        write_population(CNT_W'(0));
        pending_values = '{RV_W'(0), RV_ALL};
        write_population(CNT_W'(1));
        pending_values = {pending_values, RV_W'(5)};
        // population above the maximum behaves as the maximum
        write_population(CNT_W'(127));
        pending_values = '{RV_W'(85343), RV_W'(85344)};
        // three ranks: weights 4, 1, 0
        write_population(CNT_W'(3));
        pending_values = '{RV_W'(3), RV_W'(4), RV_W'(5)};

        // random phases over populations and idle patterns
        for (int ph = 0; ph < 9; ph++) begin
            write_population(phase_pops[ph]);
            if (ph == 2) begin
                // long receiver hold-off while the sender keeps offering
                set_idling(0);
                hold_req_seq++;
                repeat (10) pending_values = {pending_values, draw_value(phase_pops[ph])};
                // sender pauses until every result is back
                wait_drained();
            end
            set_idling(ph);
            repeat (PHASE_ITEMS) pending_values = {pending_values, draw_value(phase_pops[ph])};
        end

        wait_drained();
        repeat (TAIL_TICKS) @(posedge i_clk);
        if (error_count == 0 && expected_picks.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
